/* src/plf_pkg.sv */
// ============================================================================
// plf_pkg
// Types and constants shared by the presence LED fader and its checker.
// ============================================================================
`default_nettype none

package plf_pkg;

	typedef enum logic [1:0] {
		MODE_FADE   = 2'd0,
		MODE_BRIGHT = 2'd1,
		MODE_OFF    = 2'd2,
		MODE_FULL   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		CFG_WINDOW_MS = 2'd0,
		CFG_STEP_MS   = 2'd1,
		CFG_DUTY_TOP  = 2'd2,
		CFG_CALL_CODE = 2'd3
	} cfg_idx_t;

	localparam logic        OP_TICK   = 1'b0;
	localparam logic        OP_PACKET = 1'b1;

	localparam logic [15:0] TIMER_MAX     = 16'hFFFF;
	localparam logic [7:0]  DUTY_MAX      = 8'hFF;

	localparam logic [15:0] WINDOW_MS_RST = 16'd1000;
	localparam logic [15:0] STEP_MS_RST   = 16'd72;
	localparam logic [7:0]  DUTY_TOP_RST  = 8'd150;
	localparam logic [7:0]  CALL_CODE_RST = 8'd0;

	// result fields from the highest bit down
	typedef struct packed {
		logic [2:0] pad;
		logic       departed;
		logic       arrived;
		logic       present;
		mode_t      led_mode;
		logic [7:0] duty;
	} result_t;

endpackage

`default_nettype wire

/* src/presence_led_fader.sv */
// ============================================================================
// presence_led_fader
// Tag presence detector driving an LED duty ramp.
// ============================================================================
// Usage:
//   s_* stream: one transfer per event. s_tuser[0] is the opcode (0 = 1 ms
//   tick, 1 = packet received), s_tdata carries the packet command byte.
//   m_* stream: one result per input transfer, in order, carrying the duty,
//   LED mode, presence flag and the arrived/departed pulses.
//   cfg_* channel: register writes (0 window_ms, 1 step_ms, 2 duty_top,
//   3 call_code); always ready, to be used only while the block is idle.
// Pipeline: an accepted event is captured in the input register, evaluated
//   combinationally, and its result is registered onto m_*.
// Throughput: one event per cycle unless stalled; the state update is a single
//   pass of compare and increment logic between the input and result registers.
// Reset: arst_n clears both pipeline slots, the LED goes off at duty zero,
//   the timers clear and the registers take their reset values.
// Stall: while m_tready is low the result holds; one more event may wait in
//   the input register, after which s_tready drops.
// ============================================================================
`default_nettype none

module presence_led_fader (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] command_id
	input  wire logic [0:0]  s_tuser,   // [0] opcode

	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] duty, [9:8] led_mode, [10] present,
	                                    // [11] arrived, [12] departed, [15:13] zero

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	// configuration
	logic [15:0] window_ms_q;
	logic [15:0] step_ms_q;
	logic [7:0]  duty_top_q;
	logic [7:0]  call_code_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ms_q <= plf_pkg::WINDOW_MS_RST;
			step_ms_q   <= plf_pkg::STEP_MS_RST;
			duty_top_q  <= plf_pkg::DUTY_TOP_RST;
			call_code_q <= plf_pkg::CALL_CODE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				plf_pkg::CFG_WINDOW_MS: window_ms_q <= cfg_data;
				plf_pkg::CFG_STEP_MS:   step_ms_q   <= cfg_data;
				plf_pkg::CFG_DUTY_TOP:  duty_top_q  <= cfg_data[7:0];
				plf_pkg::CFG_CALL_CODE: call_code_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input register
	logic       in_valid_s1;
	logic       opcode_s1;
	logic [7:0] command_id_s1;
	logic       advance;

	assign advance  = in_valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			opcode_s1     <= s_tuser[0];
			command_id_s1 <= s_tdata;
		end
	end

	// state
	plf_pkg::mode_t mode_q;
	logic [7:0]     duty_q;
	logic [15:0]    step_el_q;
	logic [15:0]    window_el_q;
	logic           seen_q;
	logic           present_q;

	plf_pkg::mode_t mode_d;
	plf_pkg::mode_t mode_mid;
	logic [7:0]     duty_d;
	logic [7:0]     duty_inc;
	logic [7:0]     duty_dec;
	logic [15:0]    step_el_d;
	logic [15:0]    window_el_d;
	logic [15:0]    step_inc;
	logic [15:0]    window_inc;
	logic           seen_d;
	logic           present_d;
	logic           arrived_d;
	logic           departed_d;

	assign window_inc = (window_el_q < plf_pkg::TIMER_MAX) ? window_el_q + 16'd1 : window_el_q;
	assign step_inc   = (step_el_q < plf_pkg::TIMER_MAX) ? step_el_q + 16'd1 : step_el_q;
	assign duty_inc   = (duty_q < plf_pkg::DUTY_MAX) ? duty_q + 8'd1 : duty_q;
	assign duty_dec   = (duty_q != 8'd0) ? duty_q - 8'd1 : duty_q;

	always_comb begin
		mode_d      = mode_q;
		mode_mid    = mode_q;
		duty_d      = duty_q;
		step_el_d   = step_el_q;
		window_el_d = window_el_q;
		seen_d      = seen_q;
		present_d   = present_q;
		arrived_d   = 1'b0;
		departed_d  = 1'b0;
		if (opcode_s1 == plf_pkg::OP_PACKET) begin
			if (command_id_s1 == call_code_q) begin
				seen_d = 1'b1;
				if (!present_q) begin
					present_d = 1'b1;
					mode_d    = plf_pkg::MODE_BRIGHT;
					arrived_d = 1'b1;
				end
			end
		end else begin
			window_el_d = window_inc;
			step_el_d   = step_inc;
			if (window_inc >= window_ms_q) begin
				window_el_d = 16'd0;
				seen_d      = 1'b0;
				if (present_q && !seen_q) begin
					present_d  = 1'b0;
					mode_mid   = plf_pkg::MODE_FADE;
					departed_d = 1'b1;
				end
			end
			mode_d = mode_mid;
			if (step_inc >= step_ms_q) begin
				case (mode_mid)
					plf_pkg::MODE_BRIGHT: begin
						step_el_d = 16'd0;
						duty_d    = duty_inc;
						if (duty_inc >= duty_top_q)
							mode_d = plf_pkg::MODE_FULL;
					end
					plf_pkg::MODE_FADE: begin
						step_el_d = 16'd0;
						duty_d    = duty_dec;
						if (duty_dec == 8'd0)
							mode_d = plf_pkg::MODE_OFF;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= plf_pkg::MODE_OFF;
			duty_q      <= 8'd0;
			step_el_q   <= 16'd0;
			window_el_q <= 16'd0;
			seen_q      <= 1'b0;
			present_q   <= 1'b0;
		end else if (advance) begin
			mode_q      <= mode_d;
			duty_q      <= duty_d;
			step_el_q   <= step_el_d;
			window_el_q <= window_el_d;
			seen_q      <= seen_d;
			present_q   <= present_d;
		end
	end

	// result register
	plf_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.pad      <= 3'd0;
			res_q.departed <= departed_d;
			res_q.arrived  <= arrived_d;
			res_q.present  <= present_d;
			res_q.led_mode <= mode_d;
			res_q.duty     <= duty_d;
		end
	end

	assign m_tdata = res_q;

endmodule

`default_nettype wire

/* src/plf_checker.sv */
// ============================================================================
// plf_checker
// Port-level assertions for the presence LED fader.
// ============================================================================
`default_nettype none

module plf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);

	plf_pkg::result_t res;
	assign res = m_tdata;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// arrival always reports present and brightening
	a_arrive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.arrived |->
			res.present && res.led_mode == plf_pkg::MODE_BRIGHT && !res.departed)
		else $error("arrival inconsistent");

	// departure always reports absent and fading or already off
	a_depart: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.departed |->
			!res.present && (res.led_mode == plf_pkg::MODE_FADE ||
			res.led_mode == plf_pkg::MODE_OFF))
		else $error("departure inconsistent");

	// off means dark
	a_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.led_mode == plf_pkg::MODE_OFF |-> res.duty == 8'd0)
		else $error("led off with nonzero duty");

endmodule

bind presence_led_fader plf_checker u_plf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
